// ===== rtl/scpc_pkg.sv =====
// Shared types and constants for the stepper command packet controller.
// Depends on nothing; every rtl file imports it.
package scpc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PULSES_W    = 5;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic [7:0] CHR_MOVE     = 8'h4D;  // 'M'
  localparam logic [7:0] CHR_POSITION = 8'h50;  // 'P'
  localparam logic [7:0] CHR_ZERO     = 8'h30;  // '0'
  localparam logic [7:0] CHR_ONE      = 8'h31;  // '1'

  typedef enum logic [2:0] {
    RPL_NONE      = 3'd0,
    RPL_OK        = 3'd1,
    RPL_FAIL      = 3'd2,
    RPL_DONE      = 3'd3,
    RPL_OKDONE    = 3'd4,
    RPL_POSOKDONE = 3'd5
  } reply_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_FAIL,
    K_MOVE,
    K_POS_ZERO,
    K_POS_KEEP,
    K_POS_REPORT,
    K_TICK,
    K_LOAD
  } kind_t;

  typedef enum logic [1:0] {
    DIR_KEEP,
    DIR_FWD,
    DIR_REV
  } dir_sel_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    kind_t       kind;
    dir_sel_t    dir_sel;
    logic [31:0] data;     // step count in the low half for a move, value for a load
  } cmd_t;

endpackage

// ===== rtl/scpc_front.sv =====
// Front end: decodes an input item, checks packet checksums, builds a command.
// Depends on scpc_pkg.
module scpc_front (
  input  logic [1:0]          opcode,
  input  logic [7:0]          byte0,
  input  logic [7:0]          byte1,
  input  logic [7:0]          byte2,
  input  logic [7:0]          byte3,
  input  logic [7:0]          byte4,
  input  logic [7:0]          byte5,
  input  logic [7:0]          byte6,
  input  logic [7:0]          byte7,
  input  logic signed [31:0]  new_position,
  output scpc_pkg::cmd_t      cmd
);
  import scpc_pkg::*;

  logic [15:0] move_sum;
  logic [15:0] pos_sum;
  logic        move_ok;
  logic        pos_ok;

  assign pos_sum  = 16'(byte0) + 16'(byte1) + 16'(byte2);
  assign move_sum = pos_sum + 16'(byte3) + 16'(byte4);
  assign move_ok  = (move_sum == {byte7, byte6});
  assign pos_ok   = (pos_sum == {byte5, byte4});

  always_comb begin
    cmd.kind    = K_NONE;
    cmd.dir_sel = DIR_KEEP;
    cmd.data    = {16'd0, byte4, byte3};
    unique case (opcode)
      OP_PACKET: begin
        priority if (byte0 == CHR_MOVE) begin
          if (!move_ok) begin
            cmd.kind = K_FAIL;
          end else begin
            cmd.kind = K_MOVE;
            priority if (byte1 == CHR_ZERO) cmd.dir_sel = DIR_FWD;
            else if (byte1 == CHR_ONE)      cmd.dir_sel = DIR_REV;
            else                            cmd.dir_sel = DIR_KEEP;
          end
        end else if (byte0 == CHR_POSITION) begin
          priority if (!pos_ok)          cmd.kind = K_FAIL;
          else if (byte1 == CHR_ZERO)    cmd.kind = K_POS_ZERO;
          else if (byte1 == CHR_ONE)     cmd.kind = K_POS_REPORT;
          else                           cmd.kind = K_POS_KEEP;
        end else begin
          cmd.kind = K_NONE;
        end
      end
      OP_TICK: cmd.kind = K_TICK;
      OP_LOAD: begin
        cmd.kind = K_LOAD;
        cmd.data = new_position;
      end
      default: cmd.kind = K_NONE;
    endcase
  end

endmodule

// ===== rtl/scpc_queue.sv =====
// Short command queue between front and back end.
// Depends on scpc_pkg.
module scpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scpc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output scpc_pkg::cmd_t head
);
  import scpc_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/scpc_back.sv =====
// Back end: executes queued commands against motor state, holds the result register.
// Depends on scpc_pkg.
module scpc_back #(
  parameter int unsigned MICROSTEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  scpc_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        reply,
  output logic signed [31:0]                position,
  output logic                              stepped,
  output logic                              dir_level,
  output logic [scpc_pkg::PULSES_W-1:0]     pulses
);
  import scpc_pkg::*;

  logic [15:0]        steps_left;
  logic               forward;
  logic signed [31:0] position_count;

  logic [15:0]        steps_left_next;
  logic               forward_next;
  logic signed [31:0] position_count_next;
  reply_t             reply_next;
  logic               stepped_next;

  assign cmd_pop = cmd_valid && (!out_valid || !out_stall);

  always_comb begin
    steps_left_next     = steps_left;
    forward_next        = forward;
    position_count_next = position_count;
    reply_next          = RPL_NONE;
    stepped_next        = 1'b0;
    unique case (cmd.kind)
      K_NONE:       reply_next = RPL_NONE;
      K_FAIL:       reply_next = RPL_FAIL;
      K_MOVE: begin
        if (steps_left != '0) begin
          reply_next = RPL_FAIL;
        end else begin
          reply_next      = RPL_OK;
          steps_left_next = cmd.data[15:0];
          unique case (cmd.dir_sel)
            DIR_FWD: forward_next = 1'b1;
            DIR_REV: forward_next = 1'b0;
            default: forward_next = forward;
          endcase
        end
      end
      K_POS_ZERO: begin
        reply_next          = RPL_OKDONE;
        position_count_next = '0;
      end
      K_POS_KEEP:   reply_next = RPL_OKDONE;
      K_POS_REPORT: reply_next = RPL_POSOKDONE;
      K_TICK: begin
        if (steps_left != '0) begin
          stepped_next        = 1'b1;
          steps_left_next     = steps_left - 1'b1;
          position_count_next = forward ? position_count + 32'sd1
                                        : position_count - 32'sd1;
          if (steps_left == 16'd1) reply_next = RPL_DONE;
        end
      end
      K_LOAD:       position_count_next = $signed(cmd.data);
      default:      reply_next = RPL_NONE;
    endcase
  end

  // Result payload: load on pop, hold otherwise.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      reply     <= reply_next;
      position  <= position_count_next;
      stepped   <= stepped_next;
      dir_level <= !forward_next;
      pulses    <= stepped_next ? PULSES_W'(MICROSTEPS) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left     <= '0;
      forward        <= 1'b1;
      position_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd_pop) begin
        steps_left     <= steps_left_next;
        forward        <= forward_next;
        position_count <= position_count_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid      <= 1'b0;
      end
    end
  end

  a_step_pulses: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stepped) |-> (pulses == PULSES_W'(MICROSTEPS)))
    else $error("step issued without full pulse count");
  a_done_needs_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply == RPL_DONE) |-> stepped)
    else $error("DONE reply without a step");
  a_countdown: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.kind == K_TICK && steps_left != '0)
      |=> (steps_left == $past(steps_left) - 1'b1) && stepped && out_valid)
    else $error("tick did not count down pending steps");
  a_reported_position: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (position == position_count))
    else $error("reported position differs from state");

endmodule

// ===== rtl/stepper_command_packet_controller.sv =====
// Stepper command packet controller: front decode, command queue, back execute.
// A transfer in is held in a queue slot, then loaded into the result register.
// Throughput: one item per cycle while out_stall is low, set by the back-end state update.
// A two-entry queue and the result register let input and output stall independently.
// Reset (rst, synchronous, active high) empties the queue and the result register,
// clears the step count and position, and sets the direction forward.
module stepper_command_packet_controller #(
  parameter int unsigned MICROSTEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         byte0,
  input  logic [7:0]         byte1,
  input  logic [7:0]         byte2,
  input  logic [7:0]         byte3,
  input  logic [7:0]         byte4,
  input  logic [7:0]         byte5,
  input  logic [7:0]         byte6,
  input  logic [7:0]         byte7,
  input  logic signed [31:0] new_position,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         reply,
  output logic signed [31:0] position,
  output logic               stepped,
  output logic               dir_level,
  output logic [4:0]         pulses
);
  import scpc_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;
  logic in_xfer;

  // Stall only on a full queue, so the front never waits on the output side directly.
  assign in_stall = q_full;
  assign in_xfer  = in_valid && !in_stall;

  // Classify the item and check its checksum in the same cycle it transfers.
  scpc_front u_front (
    .opcode       (opcode),
    .byte0        (byte0),
    .byte1        (byte1),
    .byte2        (byte2),
    .byte3        (byte3),
    .byte4        (byte4),
    .byte5        (byte5),
    .byte6        (byte6),
    .byte7        (byte7),
    .new_position (new_position),
    .cmd          (front_cmd)
  );

  // Hold classified commands until the back end can take them.
  scpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_xfer),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  // Apply each command to steps, direction and position; drive the result register.
  scpc_back #(
    .MICROSTEPS (MICROSTEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .reply     (reply),
    .position  (position),
    .stepped   (stepped),
    .dir_level (dir_level),
    .pulses    (pulses)
  );

endmodule

// ===== dv/tb_stepper_command_packet_controller.sv =====
// Testbench for stepper_command_packet_controller: directed and random command traffic.
// It predicts every result in-line and compares each field as results arrive.
// Depends on rtl/scpc_pkg.sv and rtl/stepper_command_packet_controller.sv.
module tb_stepper_command_packet_controller;
  import scpc_pkg::*;

  localparam int unsigned MICROSTEPS = 16;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam logic [7:0]  CHR_STAR   = 8'h2A;  // '*'
  localparam int          ITEM_GOAL  = 1875;   // directed part plus about 1850 random

  // One input transfer; drain holds the sender until every result is back.
  typedef struct packed {
    logic               drain;
    logic [1:0]         op;
    logic [7:0][7:0]    bytes;       // bytes[k] drives port byte<k>
    logic signed [31:0] load_value;
  } ctrl_item_t;

  typedef struct packed {
    reply_t             reply;
    logic signed [31:0] position;
    logic               stepped;
    logic               dir_level;
    logic [4:0]         pulses;
  } ctrl_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  ctrl_item_t offer    = '0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         reply;
  logic signed [31:0] position;
  logic               stepped;
  logic               dir_level;
  logic [4:0]         pulses;

  ctrl_item_t   cmd_backlog[$];     // items not yet offered
  ctrl_result_t pending_replies[$]; // predicted results, oldest first
  int           fail_count = 0;
  logic         in_taken   = 1'b0;  // input transfer at the latest rising edge

  // Controller state as the predictor sees it.
  logic [15:0] steps_left_m = 16'd0;
  logic        forward_m    = 1'b1;
  logic [31:0] position_m   = 32'd0;

  always #2 clk = ~clk;

  stepper_command_packet_controller #(
    .MICROSTEPS(MICROSTEPS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (offer.op),
    .byte0       (offer.bytes[0]),
    .byte1       (offer.bytes[1]),
    .byte2       (offer.bytes[2]),
    .byte3       (offer.bytes[3]),
    .byte4       (offer.bytes[4]),
    .byte5       (offer.bytes[5]),
    .byte6       (offer.bytes[6]),
    .byte7       (offer.bytes[7]),
    .new_position(offer.load_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply       (reply),
    .position    (position),
    .stepped     (stepped),
    .dir_level   (dir_level),
    .pulses      (pulses)
  );

  // Apply one command to the predicted state and return the result it should produce.
  function automatic ctrl_result_t execute_command(input ctrl_item_t it);
    ctrl_result_t r;
    logic [15:0]  sum;
    logic [15:0]  given;
    r       = '0;
    r.reply = RPL_NONE;
    case (it.op)
      OP_PACKET: begin
        if (it.bytes[0] == CHR_MOVE) begin
          // move: checksum covers letter, sub-code, separator and the step count
          sum   = 16'(it.bytes[0]) + 16'(it.bytes[1]) + 16'(it.bytes[2])
                + 16'(it.bytes[3]) + 16'(it.bytes[4]);
          given = {it.bytes[7], it.bytes[6]};
          if (sum != given || steps_left_m != 16'd0) begin
            r.reply = RPL_FAIL;
          end else begin
            steps_left_m = {it.bytes[4], it.bytes[3]};
            if (it.bytes[1] == CHR_ZERO) forward_m = 1'b1;
            else if (it.bytes[1] == CHR_ONE) forward_m = 1'b0;
            r.reply = RPL_OK;
          end
        end else if (it.bytes[0] == CHR_POSITION) begin
          sum   = 16'(it.bytes[0]) + 16'(it.bytes[1]) + 16'(it.bytes[2]);
          given = {it.bytes[5], it.bytes[4]};
          if (sum != given) begin
            r.reply = RPL_FAIL;
          end else if (it.bytes[1] == CHR_ZERO) begin
            position_m = 32'd0;
            r.reply    = RPL_OKDONE;
          end else if (it.bytes[1] == CHR_ONE) begin
            r.reply = RPL_POSOKDONE;
          end else begin
            r.reply = RPL_OKDONE;
          end
        end
        // any other letter: leave everything alone, no reply
      end
      OP_TICK: begin
        if (steps_left_m != 16'd0) begin
          r.stepped    = 1'b1;
          r.pulses     = 5'(MICROSTEPS);
          position_m   = forward_m ? position_m + 32'd1 : position_m - 32'd1;
          steps_left_m = steps_left_m - 16'd1;
          if (steps_left_m == 16'd0) r.reply = RPL_DONE;
        end
      end
      OP_LOAD: position_m = it.load_value;
      default: ;
    endcase
    r.position  = position_m;
    r.dir_level = ~forward_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Unused bytes and the load value carry random content so every
  // bit of every field toggles.
  // ---------------------------------------------------------------------------
  function automatic ctrl_item_t random_item();
    ctrl_item_t it;
    it.drain      = 1'b0;
    it.op         = 2'($urandom_range(0, 3));
    it.bytes      = {$urandom, $urandom};
    it.load_value = $urandom;
    return it;
  endfunction

  function automatic ctrl_item_t move_packet(input logic [7:0] sub, input logic [15:0] count,
                                             input bit good_sum);
    ctrl_item_t  it;
    logic [15:0] sum;
    it          = random_item();
    it.op       = OP_PACKET;
    it.bytes[0] = CHR_MOVE;
    it.bytes[1] = sub;
    it.bytes[3] = count[7:0];
    it.bytes[4] = count[15:8];
    if ($urandom_range(0, 1)) it.bytes[5] = CHR_STAR;  // the star is never checked
    sum = 16'(it.bytes[0]) + 16'(it.bytes[1]) + 16'(it.bytes[2]) + 16'(count[7:0])
        + 16'(count[15:8]);
    if (!good_sum) sum = sum + 16'($urandom_range(1, 65535));
    {it.bytes[7], it.bytes[6]} = sum;
    return it;
  endfunction

  function automatic ctrl_item_t pos_packet(input logic [7:0] sub, input bit good_sum);
    ctrl_item_t  it;
    logic [15:0] sum;
    it          = random_item();
    it.op       = OP_PACKET;
    it.bytes[0] = CHR_POSITION;
    it.bytes[1] = sub;
    if ($urandom_range(0, 1)) it.bytes[3] = CHR_STAR;
    sum = 16'(it.bytes[0]) + 16'(it.bytes[1]) + 16'(it.bytes[2]);
    if (!good_sum) sum = sum + 16'($urandom_range(1, 65535));
    {it.bytes[5], it.bytes[4]} = sum;
    return it;
  endfunction

  function automatic ctrl_item_t tick_item();
    ctrl_item_t it;
    it    = random_item();
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic ctrl_item_t load_item(input logic signed [31:0] value);
    ctrl_item_t it;
    it            = random_item();
    it.op         = OP_LOAD;
    it.load_value = value;
    return it;
  endfunction

  // Mostly the two real sub-codes, now and then a stray character.
  function automatic logic [7:0] pick_sub();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return CHR_ZERO;
    if (roll < 90) return CHR_ONE;
    return 8'($urandom);
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: record each transfer and predict its result at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : input_capture
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) pending_replies.push_back(execute_command(offer));
  end

  // Sender: bursts of random length separated by random gaps; hold a stalled
  // payload; hold a drain-marked item until every result has come back.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : sender
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold valid and payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cmd_backlog.size() == 0 ||
                 (cmd_backlog[0].drain && pending_replies.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      offer    <= cmd_backlog.pop_front();
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        // long bursts give stretches with no idling at all
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
        case ($urandom_range(0, 9))
          0, 1:    gap_left = 0;
          2:       gap_left = $urandom_range(8, 20);
          default: gap_left = $urandom_range(1, 4);
        endcase
      end else begin
        burst_left--;
      end
    end
  end

  // Receiver: switches at random among four stall patterns; twice it holds off for a
  // long stretch so the block fills up and stalls its input.
  int unsigned rx_cycles = 0;
  int unsigned rx_mode   = 0;
  int          hold_left = 0;

  always @(negedge clk) begin : receiver
    rx_cycles++;
    if (rx_cycles == 700 || rx_cycles == 2600) hold_left = 90;
    if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= (rx_cycles % 3 == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Result side: compare every transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    ctrl_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no prediction waiting (reply %0d)", reply);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("reply", 32'(want.reply), 32'(reply));
        check_field("position", want.position, position);
        check_field("stepped", 32'(want.stepped), 32'(stepped));
        check_field("dir_level", 32'(want.dir_level), 32'(dir_level));
        check_field("pulses", 32'(want.pulses), 32'(pulses));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : run_control
    ctrl_item_t  it;
    int unsigned cnt;
    int unsigned n_ticks;
    int unsigned roll;

    // Directed: empty tick, unused opcode, unknown letters, every reply, wrap both ways.
    cmd_backlog.push_back(tick_item());                    // nothing pending
    it = random_item(); it.op = OP_UNUSED; cmd_backlog.push_back(it);
    it = '0; it.op = OP_PACKET; it.bytes = '1; it.load_value = '1;
    cmd_backlog.push_back(it);                             // letter 0xFF, all ones
    it = '0; it.op = OP_PACKET; cmd_backlog.push_back(it); // letter 0x00, all zeros
    cmd_backlog.push_back(pos_packet(CHR_ONE, 1'b1));      // report position
    cmd_backlog.push_back(load_item(32'sh7FFF_FFFF));
    cmd_backlog.push_back(move_packet(CHR_ZERO, 16'd2, 1'b1));
    cmd_backlog.push_back(move_packet(CHR_ONE, 16'hFFFF, 1'b1)); // move still pending
    cmd_backlog.push_back(tick_item());                    // wraps to most negative
    cmd_backlog.push_back(tick_item());                    // last step, DONE
    cmd_backlog.push_back(move_packet(CHR_ONE, 16'hFFFF, 1'b0)); // bad checksum
    cmd_backlog.push_back(move_packet(CHR_ONE, 16'd0, 1'b1));    // zero count, reverse
    cmd_backlog.push_back(tick_item());                    // nothing to do
    it = load_item(32'sh8000_0000); it.drain = 1'b1; cmd_backlog.push_back(it);
    cmd_backlog.push_back(move_packet(8'hFF, 16'd1, 1'b1)); // stray sub-code keeps reverse
    cmd_backlog.push_back(tick_item());                    // wraps to most positive
    cmd_backlog.push_back(pos_packet(CHR_ZERO, 1'b0));     // bad checksum
    cmd_backlog.push_back(pos_packet(CHR_ONE, 1'b0));
    cmd_backlog.push_back(pos_packet(CHR_ZERO, 1'b1));     // zero the position
    cmd_backlog.push_back(pos_packet(8'h00, 1'b1));        // stray sub-code, OK+DONE only
    cmd_backlog.push_back(load_item(-32'sd1));
    cmd_backlog.push_back(move_packet(CHR_ZERO, 16'd1, 1'b1));
    cmd_backlog.push_back(tick_item());                    // -1 + 1 wraps to zero

    // Random: mostly well-formed move-then-tick sequences, plus side traffic and noise.
    while (cmd_backlog.size() < ITEM_GOAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        cnt = ($urandom_range(0, 99) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 6);
        cmd_backlog.push_back(move_packet(pick_sub(), 16'(cnt), 1'b1));
        n_ticks = cnt + $urandom_range(0, 2);
        for (int unsigned k = 0; k < n_ticks; k++) begin
          if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
              0: cmd_backlog.push_back(pos_packet(pick_sub(), 1'b1));
              1: cmd_backlog.push_back(load_item($urandom));
              // a valid move only while steps are surely pending, so it must fail
              2: cmd_backlog.push_back(move_packet(pick_sub(), 16'($urandom), k < cnt));
              default: cmd_backlog.push_back(move_packet(pick_sub(), 16'($urandom), 1'b0));
            endcase
          end
          cmd_backlog.push_back(tick_item());
        end
      end else if (roll < 68) begin
        cmd_backlog.push_back(pos_packet(pick_sub(), $urandom_range(0, 4) != 0));
      end else if (roll < 76) begin
        cmd_backlog.push_back(load_item($urandom));
      end else if (roll < 84) begin
        // broken sequence: move cut short, the next move drains it or fails
        cnt = $urandom_range(2, 5);
        cmd_backlog.push_back(move_packet(pick_sub(), 16'(cnt), 1'b1));
        repeat ($urandom_range(0, cnt - 1)) cmd_backlog.push_back(tick_item());
      end else if (roll < 92) begin
        cmd_backlog.push_back(move_packet(pick_sub(), 16'($urandom), 1'b0));
      end else begin
        cmd_backlog.push_back(random_item());
      end
    end
    cmd_backlog[1000].drain = 1'b1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the backlog to empty and every predicted result to arrive.
    while (cmd_backlog.size() != 0 || in_valid || pending_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);  // catch any stray result

    if (fail_count == 0)
      $display("tb_stepper_command_packet_controller passed");
    else
      $display("tb_stepper_command_packet_controller failed");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("tb_stepper_command_packet_controller failed");
    $finish;
  end

endmodule
